// ===== rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg: shared types and codes for the sorted minimum priority queue.
// Holds the operation and status codes and the control word sent to cells.
// ----------------------------------------------------------------------------
package smpq_pkg;

    // Operation codes carried on the input word.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes carried on the result word.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Control word broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // an insert is taking effect this cycle
        logic rem;   // a removal of the head is taking effect this cycle
    } t_cell_ctrl;

endpackage

// ===== rtl/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain.
// Compares its key with the incoming key and keeps, loads, or takes a
// neighbor's key so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                  i_clk,
    input  smpq_pkg::t_cell_ctrl  i_ctrl,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic                  i_slot_valid,
    input  logic                  i_prev_lt,
    input  logic [KEY_WIDTH-1:0]  i_prev_key,
    input  logic [KEY_WIDTH-1:0]  i_next_key,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [KEY_WIDTH-1:0]  o_key_next,
    output logic                  o_lt
);

    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic                 w_lt;

    // A held key that is smaller than the new key stays where it is.
    assign w_lt = i_slot_valid && (r_key < i_key);

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins) begin
            if (w_lt) begin
                n_key = r_key;
            end else if (i_prev_lt) begin
                n_key = i_key;
            end else begin
                n_key = i_prev_key;
            end
        end else if (i_ctrl.rem) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;
    assign o_lt       = w_lt;

endmodule

// ===== rtl/sorted_min_priority_queue.sv =====
// The result word for an operation is registered, so it is presented in the
// cycle after the operation word is accepted.
// One push or pop per cycle; every cell compares and shifts in
// parallel, so the rate is set only by the output register being drained.
// Reset clears the entry count and the output valid; cell keys are not reset.
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: bounded min priority queue kept as a sorted chain.
// A row of compare-and-shift cells holds the keys in ascending order, so the
// smallest key always sits in the first cell.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Operation channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_value,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_smallest,
    output logic [4:0]  o_entry_count,
    output logic        o_is_empty,
    output logic        o_is_full,
    output logic [1:0]  o_status
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int EXT_W  = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;
    localparam int CEXT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [31:0]          r_smallest;
    logic [4:0]           r_entry_count;
    logic                 r_is_empty;
    logic                 r_is_full;
    logic [1:0]           r_status;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [1:0]           w_status;
    logic [EXT_W-1:0]     w_value_ext;
    logic [KEY_WIDTH-1:0] w_new_key;
    logic [EXT_W-1:0]     w_head_ext;
    logic [CEXT_W-1:0]    w_count_ext;
    smpq_pkg::t_cell_ctrl w_ctrl;

    logic [KEY_WIDTH-1:0] w_key      [CAPACITY];
    logic [KEY_WIDTH-1:0] w_key_next [CAPACITY];
    logic                 w_lt       [CAPACITY];

    // The output register decouples the two sides: a new word is taken
    // whenever the result register is empty or is being drained.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == CAP_CNT);
    assign w_empty = (r_count == '0);

    // Only the low KEY_WIDTH bits of the value take part in ordering.
    assign w_value_ext = EXT_W'(i_value);
    assign w_new_key   = w_value_ext[KEY_WIDTH-1:0];

    // Decide whether the operation takes effect or is dropped with an error.
    always_comb begin
        w_ctrl   = '0;
        w_status = smpq_pkg::ST_OK;
        n_count  = r_count;
        if (i_operation == smpq_pkg::OP_POP) begin
            if (w_empty) begin
                w_status = smpq_pkg::ST_EMPTY;
            end else begin
                w_ctrl.rem = w_accept;
                if (w_accept) begin
                    n_count = r_count - 1'b1;
                end
            end
        end else begin
            if (w_full) begin
                w_status = smpq_pkg::ST_FULL;
            end else begin
                w_ctrl.ins = w_accept;
                if (w_accept) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    // The chain of cells. Slot i holds a valid key when i is below the count.
    // The first cell sees a neighbor that is always "less", so an insert that
    // reaches it loads the new key there.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                 w_prev_lt;
            logic [KEY_WIDTH-1:0] w_prev_key;
            logic [KEY_WIDTH-1:0] w_next_key;

            if (gi == 0) begin : g_first
                assign w_prev_lt  = 1'b1;
                assign w_prev_key = w_key[gi];
            end else begin : g_mid
                assign w_prev_lt  = w_lt[gi-1];
                assign w_prev_key = w_key[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_next_key = w_key[gi];
            end else begin : g_inner
                assign w_next_key = w_key[gi+1];
            end

            smpq_cell #(
                .KEY_WIDTH (KEY_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_key        (w_new_key),
                .i_slot_valid (CNT_W'(gi) < r_count),
                .i_prev_lt    (w_prev_lt),
                .i_prev_key   (w_prev_key),
                .i_next_key   (w_next_key),
                .o_key        (w_key[gi]),
                .o_key_next   (w_key_next[gi]),
                .o_lt         (w_lt[gi])
            );
        end
    endgenerate

    // The result reflects the queue after the operation, so it is built from
    // the next head key and the next count.
    assign w_head_ext  = EXT_W'(w_key_next[0]);
    assign w_count_ext = CEXT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smallest    <= (n_count == '0) ? 32'd0 : w_head_ext[31:0];
            r_entry_count <= w_count_ext[4:0];
            r_is_empty    <= (n_count == '0);
            r_is_full     <= (n_count == CAP_CNT);
            r_status      <= w_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_smallest    = r_smallest;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_status      = r_status;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_min_priority_queue.
// A directed opening covers empty pops, extreme keys, equal keys, filling
// the queue and pushing into a full one. Random push and pop words follow,
// while both channels idle and stall. A scoreboard keeps its own sorted copy
// of the queue and checks every result word against it.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH       = 16;
    localparam int KEY_BITS    = 32;
    localparam int ITEMS       = 1250;
    localparam int CYCLE_LIMIT = 200000;

    // One result word as the queue reports it after an operation.
    typedef struct packed {
        logic [31:0] smallest;
        logic [4:0]  entry_count;
        logic        is_empty;
        logic        is_full;
        logic [1:0]  status;
    } t_queue_report;

    // The scoreboard mirrors the queue contents. Each accepted operation word
    // updates the mirror and queues the report that the block must give.
    class t_queue_scoreboard;
        logic [31:0]   keys[DEPTH];
        int            stored;
        t_queue_report awaited[$];
        int            failures;

        function new();
            stored   = 0;
            failures = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_operation(logic op, logic [31:0] value);
            t_queue_report rep;
            int            pos;
            int            i;
            rep.status = smpq_pkg::ST_OK;
            if (op == smpq_pkg::OP_POP) begin
                if (stored == 0) begin
                    rep.status = smpq_pkg::ST_EMPTY;
                end else begin
                    for (i = 1; i < stored; i++) keys[i-1] = keys[i];
                    stored--;
                end
            end else begin
                if (stored >= DEPTH) begin
                    rep.status = smpq_pkg::ST_FULL;
                end else begin
                    // Equal keys go in front of the ones already stored.
                    pos = 0;
                    while (pos < stored && keys[pos] < value) pos++;
                    for (i = stored; i > pos; i--) keys[i] = keys[i-1];
                    keys[pos] = value;
                    stored++;
                end
            end
            rep.smallest    = (stored > 0) ? keys[0] : 32'd0;
            rep.entry_count = 5'(stored);
            rep.is_empty    = (stored == 0);
            rep.is_full     = (stored >= DEPTH);
            awaited.push_back(rep);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_report(t_queue_report got);
            t_queue_report want;
            if (awaited.size() == 0) begin
                $display("%0t: result word with no operation pending, actual %0h",
                         $time, got);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("smallest",    want.smallest,    got.smallest);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_empty",    want.is_empty,    got.is_empty);
            compare_field("is_full",     want.is_full,     got.is_full);
            compare_field("status",      want.status,      got.status);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] smallest;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        is_full;
    logic [1:0]  status;

    int                send_idle_pct;
    int                recv_stall_pct;
    int                cycle_count;
    t_queue_scoreboard sb;

    sorted_min_priority_queue #(
        .CAPACITY  (DEPTH),
        .KEY_WIDTH (KEY_BITS)
    ) uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_value       (value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_smallest    (smallest),
        .o_entry_count (entry_count),
        .o_is_empty    (is_empty),
        .o_is_full     (is_full),
        .o_status      (status)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver stalls at random, at the rate the current phase sets.
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // Both handshakes are sampled at the clock edge, before any driver here
    // or in the block has updated. The operation word is noted first, so a
    // block that answered in the same cycle would still be checked properly.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_operation(operation, value);
            if (out_valid && !out_stall) begin
                sb.check_report('{smallest, entry_count, is_empty, is_full, status});
            end
        end
    end

    // Watchdog: a run that takes this long has hung somewhere.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offers one operation word and returns once the block has taken it.
    // Valid stays high on return, so back-to-back words need no low cycle.
    task automatic send_word(logic op, logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= key;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // The sender holds off until every result word it is owed has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Keys lean toward the extremes and a tiny range, so that ties and the
    // ordering at both ends of the key space come up often.
    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom_range(7));
            4:       return 32'hFFFF_FFF8 + 32'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    logic [31:0] fill_keys[14] = '{
        32'd5, 32'd5, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFE,
        32'd5, 32'd3, 32'd9, 32'hFFFF_FFFF, 32'd2, 32'd4, 32'd6
    };

    initial begin
        int push_pct;
        int per_phase;
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = smpq_pkg::OP_PUSH;
        value          = 32'd0;
        send_idle_pct  = 20;
        recv_stall_pct = 74;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: a pop on the empty queue, both extreme keys, a
        // fill to capacity with ties, a push into the full queue, then pops
        // that carry a nonzero key which the block must ignore.
        send_word(smpq_pkg::OP_POP, 32'd0);
        send_word(smpq_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_word(smpq_pkg::OP_PUSH, 32'h0000_0000);
        foreach (fill_keys[k]) send_word(smpq_pkg::OP_PUSH, fill_keys[k]);
        send_word(smpq_pkg::OP_PUSH, 32'd0);
        repeat (4) send_word(smpq_pkg::OP_POP, 32'hFFFF_FFFF);

        // Random part in three phases of idling. In each stretch of 32 words
        // the mix leans to pushes, to pops or to neither, so the queue keeps
        // swinging between empty and full and both error cases recur.
        per_phase = ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 74 : 0;
            recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 20 : 0;
            push_pct = 50;
            for (int n = 0; n < per_phase; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(2))
                        0:       push_pct = 85;
                        1:       push_pct = 15;
                        default: push_pct = 50;
                    endcase
                end
                send_word(($urandom_range(99) < push_pct) ? smpq_pkg::OP_PUSH
                                                          : smpq_pkg::OP_POP,
                          pick_key());
            end
        end

        // Let the last result words come back, then keep watching the result
        // channel in case the block sends anything it should not.
        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
verif/testbench.sv
